[rtl/lcpd_pkg.sv]
`timescale 1ns / 1ps

package lcpd_pkg;

  localparam int MAX_ARGUMENTS = 32;
  localparam int BUFFER_BYTES  = 8192;
  localparam int QUEUE_DEPTH   = 4;

  localparam int LEN_W = 14;
  localparam int IDX_W = 6;

  localparam logic [LEN_W-1:0] SAT14 = {LEN_W{1'b1}};

  localparam logic [LEN_W-1:0] PAYLOAD_LIMIT_RST =
    (BUFFER_BYTES > 16383) ? SAT14 : LEN_W'(BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LINE_LIMIT_RST =
    (BUFFER_BYTES - 1 > 16383) ? SAT14 : LEN_W'(BUFFER_BYTES - 1);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_ARG     = 2'd1;
  localparam logic [1:0] KIND_HDR_END = 2'd2;
  localparam logic [1:0] KIND_PAYLOAD = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LEN      = 2'd1;
  localparam logic [1:0] ERR_LINE     = 2'd2;

  localparam logic REG_PAYLOAD_LIMIT = 1'b0;
  localparam logic REG_LINE_LIMIT    = 1'b1;

  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_LENGTH  = 6'b000010,
    PH_HEADER  = 6'b000100,
    PH_TAIL    = 6'b001000,
    PH_RESYNC  = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  // One classified byte as it travels from the front end to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       is_nl;
    logic       is_star;
    logic       is_colon;
    logic       is_digit;
    logic       is_nul;
  } cls_t;

  typedef struct packed {
    logic [LEN_W-1:0] payload_limit;
    logic [LEN_W-1:0] line_limit;
  } limits_t;

endpackage

[rtl/lcpd_in_if.sv]
`timescale 1ns / 1ps

interface lcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[rtl/lcpd_out_if.sv]
`timescale 1ns / 1ps

interface lcpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  logic [1:0]                  token_kind;
  logic [lcpd_pkg::IDX_W-1:0]  arg_index;
  logic [lcpd_pkg::LEN_W-1:0]  payload_length;
  logic [lcpd_pkg::IDX_W-1:0]  arg_count;
  logic                        message_last;
  logic [1:0]                  error_code;

  modport source (output valid, output out_byte, output token_kind, output arg_index,
                  output payload_length, output arg_count, output message_last,
                  output error_code, input ready);
  modport sink (input valid, input out_byte, input token_kind, input arg_index,
                input payload_length, input arg_count, input message_last,
                input error_code, output ready);
endinterface

[rtl/line_command_payload_deframer_top.sv]
`timescale 1ns / 1ps
// Path: an accepted byte is written into the queue, then parsed and its result registered at the output.
// Throughput: one byte per cycle while the output is not stalled, set by the parser's per-byte state update.
// A short queue between the byte classifier and the parser absorbs output stalls.
// Reset (rst, synchronous, active high) empties the queue and output register, returns
// the parser to line start and loads both limit registers with their reset values.

module line_command_payload_deframer_top #(
  parameter int QUEUE_DEPTH = lcpd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  lcpd_in_if.sink     src,
  lcpd_out_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CLS_W = $bits(lcpd_pkg::cls_t);

  lcpd_pkg::limits_t limits;
  lcpd_pkg::cls_t    push_cls;
  lcpd_pkg::cls_t    head_cls;
  logic [CLS_W-1:0]  head_bits;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.payload_limit <= lcpd_pkg::PAYLOAD_LIMIT_RST;
      limits.line_limit    <= lcpd_pkg::LINE_LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == lcpd_pkg::REG_PAYLOAD_LIMIT) begin
        limits.payload_limit <= pwdata[lcpd_pkg::LEN_W-1:0];
      end else begin
        limits.line_limit <= pwdata[lcpd_pkg::LEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lcpd_pkg::REG_LINE_LIMIT) begin
      prdata = {{(32 - lcpd_pkg::LEN_W){1'b0}}, limits.line_limit};
    end else begin
      prdata = {{(32 - lcpd_pkg::LEN_W){1'b0}}, limits.payload_limit};
    end
  end

  lcpd_front u_front (
    .src    (src),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_cls)
  );

  lcpd_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_bits),
    .empty     (q_empty)
  );

  assign head_cls = lcpd_pkg::cls_t'(head_bits);

  lcpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .limits  (limits),
    .q_empty (q_empty),
    .q_data  (head_cls),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

[rtl/lcpd_fifo.sv]
`timescale 1ns / 1ps

module lcpd_fifo #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/lcpd_front.sv]
`timescale 1ns / 1ps

module lcpd_front (
  lcpd_in_if.sink              src,
  input  logic                 q_full,
  output logic                 q_push,
  output lcpd_pkg::cls_t       q_data
);

  assign src.ready = !q_full;
  assign q_push    = src.valid && !q_full;

  always_comb begin
    q_data.data     = src.in_byte;
    q_data.is_nl    = (src.in_byte == lcpd_pkg::CH_NL);
    q_data.is_star  = (src.in_byte == lcpd_pkg::CH_STAR);
    q_data.is_colon = (src.in_byte == lcpd_pkg::CH_COLON);
    q_data.is_digit = (src.in_byte >= lcpd_pkg::CH_DIG0) &&
                      (src.in_byte <= lcpd_pkg::CH_DIG9);
    q_data.is_nul   = (src.in_byte == lcpd_pkg::CH_NUL);
  end

endmodule

[rtl/lcpd_back.sv]
`timescale 1ns / 1ps

module lcpd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lcpd_pkg::limits_t    limits,
  input  logic                 q_empty,
  input  lcpd_pkg::cls_t       q_data,
  output logic                 q_pop,
  lcpd_out_if.source           res
);

  localparam int LEN_W = lcpd_pkg::LEN_W;
  localparam int IDX_W = lcpd_pkg::IDX_W;

  lcpd_pkg::phase_t  phase, phase_next;
  logic [LEN_W-1:0]  acc, acc_next;
  logic              ovf, ovf_next;
  logic [IDX_W-1:0]  argc, argc_next;
  logic [LEN_W-1:0]  lbc, lbc_next;
  logic [LEN_W-1:0]  rem, rem_next;

  logic              res_valid;
  logic              adv;

  logic              e_valid;
  logic [7:0]        e_byte;
  logic [1:0]        e_kind;
  logic [IDX_W-1:0]  e_idx;
  logic [LEN_W-1:0]  e_len;
  logic [IDX_W-1:0]  e_cnt;
  logic              e_last;
  logic [1:0]        e_err;

  logic              in_line;
  logic              first;
  logic              skip;
  logic              err_len;
  logic              last_hdr;
  lcpd_pkg::phase_t  ph_c;
  logic [LEN_W:0]    lbc_inc;
  logic [LEN_W+3:0]  acc_x10;

  // The parser takes the queue head whenever the output slot is free or draining.
  assign adv   = !q_empty && (!res_valid || res.ready);
  assign q_pop = adv;

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    ovf_next   = ovf;
    argc_next  = argc;
    lbc_next   = lbc;
    rem_next   = rem;
    e_valid    = 1'b0;
    e_byte     = '0;
    e_kind     = lcpd_pkg::KIND_NAME;
    e_idx      = '0;
    e_len      = '0;
    e_cnt      = '0;
    e_last     = 1'b0;
    e_err      = lcpd_pkg::ERR_NONE;
    skip       = 1'b0;
    in_line    = (phase == lcpd_pkg::PH_LENGTH) || (phase == lcpd_pkg::PH_HEADER) ||
                 (phase == lcpd_pkg::PH_TAIL);
    first      = !in_line;
    ph_c       = in_line ? phase : lcpd_pkg::PH_HEADER;
    lbc_inc    = (in_line ? {1'b0, lbc} : '0) + 1'b1;
    acc_x10    = {4'b0, acc} * (LEN_W + 4)'(10) + {(LEN_W)'(0), q_data.data[3:0]};
    err_len    = ovf || (acc > limits.payload_limit);
    last_hdr   = err_len || (acc == '0);

    if (phase == lcpd_pkg::PH_PAYLOAD && rem != '0) begin
      e_valid  = 1'b1;
      e_byte   = q_data.data;
      e_kind   = lcpd_pkg::KIND_PAYLOAD;
      e_last   = (rem == LEN_W'(1));
      rem_next = rem - 1'b1;
      if (rem == LEN_W'(1)) begin
        phase_next = lcpd_pkg::PH_START;
      end
    end else if (phase == lcpd_pkg::PH_RESYNC) begin
      if (q_data.is_nl) begin
        phase_next = lcpd_pkg::PH_START;
      end
    end else if (!in_line && q_data.is_nl) begin
      // Blank lines between messages are dropped.
      phase_next = lcpd_pkg::PH_START;
    end else if (q_data.is_nl) begin
      // A newline here always closes a line already in progress.
      e_valid = 1'b1;
      e_kind  = lcpd_pkg::KIND_HDR_END;
      e_len   = acc;
      e_cnt   = argc;
      e_last  = last_hdr;
      e_err   = err_len ? lcpd_pkg::ERR_LEN : lcpd_pkg::ERR_NONE;
      if (last_hdr) begin
        phase_next = lcpd_pkg::PH_START;
      end else begin
        rem_next   = acc;
        phase_next = lcpd_pkg::PH_PAYLOAD;
      end
    end else begin
      if (first) begin
        acc_next  = '0;
        ovf_next  = 1'b0;
        argc_next = '0;
        lbc_next  = '0;
      end
      if (lbc_inc > {1'b0, limits.line_limit}) begin
        e_valid    = 1'b1;
        e_kind     = lcpd_pkg::KIND_HDR_END;
        e_len      = first ? '0 : acc;
        e_cnt      = first ? '0 : argc;
        e_last     = 1'b1;
        e_err      = lcpd_pkg::ERR_LINE;
        phase_next = lcpd_pkg::PH_RESYNC;
      end else begin
        lbc_next = lbc_inc[LEN_W-1:0];
        if (first && q_data.is_star) begin
          phase_next = lcpd_pkg::PH_LENGTH;
        end else begin
          if (ph_c == lcpd_pkg::PH_LENGTH) begin
            if (q_data.is_digit) begin
              skip = 1'b1;
              if (ovf || acc_x10 > {4'b0, lcpd_pkg::SAT14}) begin
                acc_next = lcpd_pkg::SAT14;
                ovf_next = 1'b1;
              end else begin
                acc_next = acc_x10[LEN_W-1:0];
              end
            end else begin
              ph_c = lcpd_pkg::PH_HEADER;
              skip = q_data.is_colon;
            end
          end
          if (!skip && ph_c != lcpd_pkg::PH_TAIL) begin
            if (q_data.is_nul) begin
              ph_c = lcpd_pkg::PH_TAIL;
            end else if (q_data.is_colon &&
                         argc_next < IDX_W'(lcpd_pkg::MAX_ARGUMENTS)) begin
              argc_next = argc_next + 1'b1;
            end else begin
              e_valid = 1'b1;
              e_byte  = q_data.data;
              e_kind  = (argc_next != '0) ? lcpd_pkg::KIND_ARG : lcpd_pkg::KIND_NAME;
              e_idx   = argc_next;
            end
          end
          phase_next = ph_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lcpd_pkg::PH_START;
      acc       <= '0;
      ovf       <= 1'b0;
      argc      <= '0;
      lbc       <= '0;
      rem       <= '0;
      res_valid <= 1'b0;
    end else begin
      // Advancing implies any held transaction is taken at this edge.
      res_valid <= adv ? e_valid : (res_valid && !res.ready);
      if (adv) begin
        phase <= phase_next;
        acc   <= acc_next;
        ovf   <= ovf_next;
        argc  <= argc_next;
        lbc   <= lbc_next;
        rem   <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e_valid) begin
      res.out_byte       <= e_byte;
      res.token_kind     <= e_kind;
      res.arg_index      <= e_idx;
      res.payload_length <= e_len;
      res.arg_count      <= e_cnt;
      res.message_last   <= e_last;
      res.error_code     <= e_err;
    end
  end

  assign res.valid = res_valid;

endmodule
